@@ design/kaf_pkg.sv @@
// Shared widths, reset values, register indexes and saturation helpers for the angle filter.
`timescale 1ns / 1ps

package kaf_pkg;

  localparam int AngW    = 32;   // Q16.16 angles and rates
  localparam int CovW    = 32;   // Q8.24 covariance, noises and gains
  localparam int DtW     = 16;   // Q0.16 time step
  localparam int OpW     = 36;   // multiplier operand width, signed
  localparam int ResW    = 56;   // rounded and rescaled product width
  localparam int DenW    = 34;   // innovation variance width, signed
  localparam int CovFrac = 24;
  localparam int DtFrac  = 16;
  localparam int WideW   = 58;   // width of a sum ahead of saturation

  localparam logic [CovW-1:0] ApnReset = 32'd1678;
  localparam logic [CovW-1:0] BpnReset = 32'd5033;
  localparam logic [CovW-1:0] MnReset  = 32'd15099494;
  localparam logic [CovW-1:0] PInit    = 32'd1677722;

  localparam logic signed [31:0] S32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CFG_ANGLE_NOISE = 2'd0,
    CFG_BIAS_NOISE  = 2'd1,
    CFG_MEAS_NOISE  = 2'd2
  } cfg_idx_e;

  // Clamp a wide signed value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [WideW-1:0] v);
    logic all_same;
    all_same = (v[WideW-1:31] == '0) || (v[WideW-1:31] == '1);
    if (all_same) return v[31:0];
    return v[WideW-1] ? S32Min : S32Max;
  endfunction

  function automatic logic [OpW-1:0] mag_op(input logic signed [OpW-1:0] v);
    return v[OpW-1] ? OpW'(-v) : OpW'(v);
  endfunction

endpackage

@@ design/kaf_mul.sv @@
// Bit-serial signed multiplier with round-to-nearest rescale by 2^16 or 2^24.
`timescale 1ns / 1ps

module kaf_mul import kaf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [OpW-1:0]  a_i,
  input  logic signed [OpW-1:0]  b_i,
  input  logic                   sh24_i,
  output logic                   done_o,
  output logic signed [ResW-1:0] res_o
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_NEG, M_RND} mstate_e;

  localparam logic [5:0] CntLast = 6'(OpW - 1);

  mstate_e                   state_q;
  logic [5:0]                cnt_q;
  logic [2*OpW:0]            acc_q;
  logic [OpW-1:0]            amag_q;
  logic                      neg_q, sh24_q, done_q;
  logic signed [2*OpW:0]     prod_q;
  logic signed [ResW-1:0]    res_q;

  logic [OpW:0]              sum;
  logic [2*OpW:0]            acc_d;
  logic signed [2*OpW:0]     half, rnd_sum, shifted;

  // One multiplier bit per cycle, LSB first; the partial sum shifts right.
  assign sum   = acc_q[2*OpW:OpW] + (acc_q[0] ? {1'b0, amag_q} : '0);
  assign acc_d = {1'b0, sum, acc_q[OpW-1:1]};

  assign half    = sh24_q ? ((2*OpW+1)'(1) << (CovFrac - 1)) : ((2*OpW+1)'(1) << (DtFrac - 1));
  assign rnd_sum = prod_q + half;
  assign shifted = sh24_q ? (rnd_sum >>> CovFrac) : (rnd_sum >>> DtFrac);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      amag_q  <= '0;
      neg_q   <= 1'b0;
      sh24_q  <= 1'b0;
      done_q  <= 1'b0;
      prod_q  <= '0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            acc_q   <= {(OpW+1)'(0), mag_op(b_i)};
            amag_q  <= mag_op(a_i);
            neg_q   <= a_i[OpW-1] ^ b_i[OpW-1];
            sh24_q  <= sh24_i;
            cnt_q   <= '0;
            state_q <= M_RUN;
          end
        end
        M_RUN: begin
          acc_q <= acc_d;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == CntLast) state_q <= M_NEG;
        end
        M_NEG: begin
          prod_q  <= neg_q ? -$signed({1'b0, acc_q[2*OpW-1:0]})
                           : $signed({1'b0, acc_q[2*OpW-1:0]});
          state_q <= M_RND;
        end
        M_RND: begin
          res_q   <= shifted[ResW-1:0];
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ design/kaf_div.sv @@
// Bit-serial restoring divider for the Kalman gains, with saturation and zero divisor.
`timescale 1ns / 1ps

module kaf_div import kaf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [CovW-1:0] num_i,
  input  logic signed [DenW-1:0] den_i,
  output logic                   done_o,
  output logic signed [CovW-1:0] quot_o
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_e;

  localparam int QW = CovW + CovFrac;
  localparam logic [5:0] CntLast = 6'(QW - 1);

  dstate_e                 state_q;
  logic [5:0]              cnt_q;
  logic [QW-1:0]           dq_q;
  logic [DenW-1:0]         dmag_q, rem_q;
  logic                    neg_q, num_neg_q, num_zero_q, den_zero_q, done_q;
  logic signed [CovW-1:0]  quot_q;

  logic [DenW:0]           trial;
  logic                    ge;
  logic [DenW:0]           diff;
  logic [CovW-1:0]         num_mag;
  logic signed [CovW-1:0]  fin_val;

  assign num_mag = num_i[CovW-1] ? CovW'(-num_i) : CovW'(num_i);
  assign trial   = {rem_q, dq_q[QW-1]};
  assign ge      = trial >= {1'b0, dmag_q};
  assign diff    = trial - {1'b0, dmag_q};

  always_comb begin
    if (den_zero_q) begin
      fin_val = num_neg_q ? S32Min : (num_zero_q ? '0 : S32Max);
    end else if (neg_q) begin
      fin_val = (dq_q > QW'(33'h1_0000_0000 >> 1)) ? S32Min : -$signed(dq_q[CovW-1:0]);
    end else begin
      fin_val = (dq_q > QW'(S32Max)) ? S32Max : $signed(dq_q[CovW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= D_IDLE;
      cnt_q      <= '0;
      dq_q       <= '0;
      dmag_q     <= '0;
      rem_q      <= '0;
      neg_q      <= 1'b0;
      num_neg_q  <= 1'b0;
      num_zero_q <= 1'b0;
      den_zero_q <= 1'b0;
      done_q     <= 1'b0;
      quot_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            dq_q       <= {num_mag, CovFrac'(0)};
            dmag_q     <= den_i[DenW-1] ? DenW'(-den_i) : DenW'(den_i);
            rem_q      <= '0;
            neg_q      <= num_i[CovW-1] ^ den_i[DenW-1];
            num_neg_q  <= num_i[CovW-1];
            num_zero_q <= (num_i == '0);
            den_zero_q <= (den_i == '0);
            cnt_q      <= '0;
            state_q    <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
          dq_q  <= {dq_q[QW-2:0], ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == CntLast) state_q <= D_FIN;
        end
        D_FIN: begin
          quot_q  <= fin_val;
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ design/kalman_angle_filter.sv @@
// Top level of the two-state angle and gyro bias Kalman filter.
//
//  Channel   Direction  Handshake                  Payload
//  in        input      in_valid_i / in_stall_o    measured_angle_i, gyro_rate_i, time_step_i
//  out       output     out_valid_o / out_stall_i  filtered_angle_o
//  cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One transaction runs ten multiplies on the bit-serial multiplier
// and two gain divides on the bit-serial divider.
// One item is in work at a time; the input stalls until the sequencer is idle again.
// Reset restores the noise registers, zeroes the estimates and loads the covariance.
// A finished result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps

module kalman_angle_filter import kaf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [AngW-1:0] measured_angle_i,
  input  logic signed [AngW-1:0] gyro_rate_i,
  input  logic [DtW-1:0]         time_step_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [AngW-1:0] filtered_angle_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [CovW-1:0]        cfg_data_i
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_e;
  typedef enum logic [3:0] {
    ST_RATE, ST_DTP11, ST_P00, ST_P11, ST_K0, ST_K1,
    ST_BIAS, ST_ANG, ST_P10C, ST_P11C, ST_P01C, ST_P00C
  } step_e;

  state_e                 state_q;
  step_e                  step_q;
  logic [CovW-1:0]        apn_q, bpn_q, mn_q;
  logic signed [AngW-1:0] meas_q, gyro_q;
  logic [DtW-1:0]         dt_q;
  logic signed [AngW-1:0] ang_q, bias_q;
  logic signed [CovW-1:0] p00_q, p01_q, p10_q, p11_q, k0_q, k1_q;
  logic signed [OpW-1:0]  inner_q;
  logic                   out_valid_q;
  logic signed [AngW-1:0] out_angle_q;

  logic signed [OpW-1:0]  op_a, op_b, dt_op, y_op;
  logic                   sh24, is_div, mul_done, div_done, unit_done;
  logic signed [ResW-1:0] mul_res;
  logic signed [CovW-1:0] div_num, div_quot;
  logic signed [DenW-1:0] den;
  logic signed [WideW-1:0] res_w;

  function automatic logic signed [WideW-1:0] wide32(input logic signed [31:0] v);
    return {{(WideW-32){v[31]}}, v};
  endfunction

  function automatic logic signed [OpW-1:0] op32(input logic signed [31:0] v);
    return {{(OpW-32){v[31]}}, v};
  endfunction

  assign dt_op  = {(OpW-DtW)'(0), dt_q};
  assign y_op   = op32(meas_q) - op32(ang_q);
  assign is_div = (step_q == ST_K0) || (step_q == ST_K1);
  assign res_w  = {{(WideW-ResW){mul_res[ResW-1]}}, mul_res};
  assign den    = {{(DenW-CovW){p00_q[CovW-1]}}, p00_q} + {(DenW-CovW)'(0), mn_q};
  assign div_num = (step_q == ST_K1) ? p10_q : p00_q;
  assign unit_done = mul_done || div_done;

  always_comb begin
    op_a = dt_op;
    op_b = dt_op;
    sh24 = 1'b1;
    case (step_q)
      ST_RATE:  begin op_a = dt_op; op_b = op32(gyro_q) - op32(bias_q); sh24 = 1'b0; end
      ST_DTP11: begin op_a = dt_op; op_b = op32(p11_q); sh24 = 1'b0; end
      ST_P00:   begin op_a = dt_op; op_b = inner_q; sh24 = 1'b0; end
      ST_P11:   begin op_a = {(OpW-CovW)'(0), bpn_q}; op_b = dt_op; sh24 = 1'b0; end
      ST_BIAS:  begin op_a = op32(k1_q); op_b = y_op; end
      ST_ANG:   begin op_a = op32(k0_q); op_b = y_op; end
      ST_P10C:  begin op_a = op32(k1_q); op_b = op32(p00_q); end
      ST_P11C:  begin op_a = op32(k1_q); op_b = op32(p01_q); end
      ST_P01C:  begin op_a = op32(k0_q); op_b = op32(p01_q); end
      ST_P00C:  begin op_a = op32(k0_q); op_b = op32(p00_q); end
      default:  begin op_a = dt_op; op_b = dt_op; end
    endcase
  end

  kaf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == S_ISSUE) && !is_div),
    .a_i     (op_a),
    .b_i     (op_b),
    .sh24_i  (sh24),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  kaf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == S_ISSUE) && is_div),
    .num_i   (div_num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= ST_RATE;
      apn_q       <= ApnReset;
      bpn_q       <= BpnReset;
      mn_q        <= MnReset;
      meas_q      <= '0;
      gyro_q      <= '0;
      dt_q        <= '0;
      ang_q       <= '0;
      bias_q      <= '0;
      p00_q       <= PInit;
      p01_q       <= '0;
      p10_q       <= '0;
      p11_q       <= PInit;
      k0_q        <= '0;
      k1_q        <= '0;
      inner_q     <= '0;
      out_valid_q <= 1'b0;
      out_angle_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ANGLE_NOISE: apn_q <= cfg_data_i;
          CFG_BIAS_NOISE:  bpn_q <= cfg_data_i;
          CFG_MEAS_NOISE:  mn_q  <= cfg_data_i;
          default: ;
        endcase
      end

      // In the output state the sequencer itself decides the valid flag.
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            meas_q  <= measured_angle_i;
            gyro_q  <= gyro_rate_i;
            dt_q    <= time_step_i;
            step_q  <= ST_RATE;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (unit_done) begin
            case (step_q)
              ST_RATE:  ang_q <= sat32(wide32(ang_q) + res_w);
              ST_DTP11: begin
                // The angle covariance growth uses P01 and P10 from before this step.
                inner_q <= $signed(mul_res[OpW-1:0]) - op32(p01_q) - op32(p10_q)
                           + $signed({(OpW-CovW)'(0), apn_q});
                p01_q   <= sat32(wide32(p01_q) - res_w);
                p10_q   <= sat32(wide32(p10_q) - res_w);
              end
              ST_P00:   p00_q  <= sat32(wide32(p00_q) + res_w);
              ST_P11:   p11_q  <= sat32(wide32(p11_q) + res_w);
              ST_K0:    k0_q   <= div_quot;
              ST_K1:    k1_q   <= div_quot;
              ST_BIAS:  bias_q <= sat32(wide32(bias_q) + res_w);
              ST_ANG:   ang_q  <= sat32(wide32(ang_q) + res_w);
              ST_P10C:  p10_q  <= sat32(wide32(p10_q) - res_w);
              ST_P11C:  p11_q  <= sat32(wide32(p11_q) - res_w);
              ST_P01C:  p01_q  <= sat32(wide32(p01_q) - res_w);
              ST_P00C:  p00_q  <= sat32(wide32(p00_q) - res_w);
              default: ;
            endcase
            if (step_q == ST_P00C) begin
              state_q <= S_OUT;
            end else begin
              step_q  <= step_e'(4'(step_q) + 4'd1);
              state_q <= S_ISSUE;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_angle_q <= ang_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign filtered_angle_o = out_angle_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_ISSUE)
    else $error("accepted transaction did not start the sequencer");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> state_q == S_WAIT)
    else $error("arithmetic unit finished outside the wait state");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result appeared without a finished transaction");

endmodule
